>>> hw/rtl/ert_pkg.sv
`default_nettype none
package ert_pkg;

  localparam int TABLE_DEPTH_DEF = 20;
  localparam int KEY_BITS_DEF    = 8;
  localparam int TIME_W          = 32;
  localparam int CMD_W           = 2;
  localparam int IN_KEY_W        = 8;
  localparam int OUT_CNT_W       = 7;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd30000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SWEEP = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/ert_ram.sv
`default_nettype none
module ert_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/expiring_reservation_table_unit.sv
// Expiring reservation table. Each input item carries a command, a section
// key and the current time. A sweep removes every entry whose expiry is
// strictly below the given time and compacts the survivors in order; an add
// appends the key with expiry now plus the configured timeout when the table
// has room; a count reports how many entries hold the key. Every item yields
// exactly one result item with the match count, the add flag and the
// occupancy after the operation.
// Both channels use valid and ready. The configuration port writes the
// timeout at any edge with cfg_wr_en high; the user must see that it is
// written only while idle; the block itself does not enforce this.
// Add and no-op items go from idle to the done state, which loads the
// output register once it is free. Sweep and count read the table through
// one memory port, one entry per cycle, in the scan state before done.
// The block returns to idle once the result has moved into the output
// register, so it takes no new item before it is through with the last.
// A stalled receiver holds the result in the output register and the block
// stops before loading the next result. Reset empties the table and sets the
// timeout to 30000; table contents are not cleared.
`default_nettype none
module expiring_reservation_table_unit #(
  parameter int TABLE_DEPTH = ert_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = ert_pkg::KEY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ert_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [ert_pkg::IN_KEY_W-1:0]   in_section_key,
  input  wire logic [ert_pkg::TIME_W-1:0]     in_now_time,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [ert_pkg::OUT_CNT_W-1:0]  out_match_count,
  output logic                                out_add_accepted,
  output logic      [ert_pkg::OUT_CNT_W-1:0]  out_occupancy,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ert_pkg::TIME_W-1:0]     cfg_wr_data
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int EW   = KEY_BITS + ert_pkg::TIME_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  ert_pkg::state_t state_r, state_nxt;
  ert_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]       key_r, key_nxt;
  logic [ert_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [ert_pkg::TIME_W-1:0] timeout_r, timeout_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic          pend_r, pend_nxt;
  logic          add_ok_r, add_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ert_pkg::OUT_CNT_W-1:0] out_match_r, out_match_nxt;
  logic                          out_add_r, out_add_nxt;
  logic [ert_pkg::OUT_CNT_W-1:0] out_occ_r, out_occ_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [KEY_BITS-1:0]        rd_key;
  logic [ert_pkg::TIME_W-1:0] rd_exp;
  logic                       keep;
  logic                       in_acc;
  logic                       scan_more;
  logic                       scan_end;
  logic                       out_free;

  ert_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key    = ram_rdata[EW-1:ert_pkg::TIME_W];
  assign rd_exp    = ram_rdata[ert_pkg::TIME_W-1:0];
  assign in_ready  = (state_r == ert_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign scan_more = (rd_ptr_r < count_r);
  assign scan_end  = !scan_more && !pend_r;
  assign out_free  = !out_valid_r || out_ready;

  // The one compare unit: key match for count, not-expired for sweep.
  always_comb begin
    if (cmd_r == ert_pkg::CMD_SWEEP) begin
      keep = !(now_r > rd_exp);
    end else begin
      keep = (rd_key == key_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ert_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == ert_pkg::CMD_SWEEP || in_cmd == ert_pkg::CMD_COUNT) begin
            state_nxt = ert_pkg::ST_SCAN;
          end else begin
            state_nxt = ert_pkg::ST_DONE;
          end
        end
      end
      ert_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ert_pkg::ST_DONE;
        end
      end
      ert_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ert_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ert_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    now_nxt       = now_r;
    timeout_nxt   = cfg_wr_en ? cfg_wr_data : timeout_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    pend_nxt      = 1'b0;
    add_ok_nxt    = add_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_match_nxt = out_match_r;
    out_add_nxt   = out_add_r;
    out_occ_nxt   = out_occ_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = {KEY_BITS'(in_section_key), in_now_time + timeout_r};
    ram_raddr     = rd_ptr_r[AW-1:0];
    unique case (state_r)
      ert_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = ert_pkg::cmd_t'(in_cmd);
          key_nxt    = KEY_BITS'(in_section_key);
          now_nxt    = in_now_time;
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          add_ok_nxt = 1'b0;
          if (in_cmd == ert_pkg::CMD_ADD && count_r < DEPTH_C) begin
            ram_we     = 1'b1;
            count_nxt  = count_r + 1'b1;
            add_ok_nxt = 1'b1;
          end
        end
      end
      ert_pkg::ST_SCAN: begin
        if (scan_more) begin
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (pend_r && keep) begin
          wr_ptr_nxt = wr_ptr_r + 1'b1;
          if (cmd_r == ert_pkg::CMD_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = wr_ptr_r[AW-1:0];
            ram_wdata = ram_rdata;
          end
        end
        if (scan_end && cmd_r == ert_pkg::CMD_SWEEP) begin
          count_nxt = wr_ptr_r;
        end
      end
      ert_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = (cmd_r == ert_pkg::CMD_COUNT) ?
                          ert_pkg::OUT_CNT_W'(wr_ptr_r) : '0;
          out_add_nxt   = add_ok_r;
          out_occ_nxt   = ert_pkg::OUT_CNT_W'(count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ert_pkg::ST_IDLE;
      count_r     <= '0;
      timeout_r   <= ert_pkg::TIMEOUT_RST;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      timeout_r   <= timeout_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    now_r       <= now_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    add_ok_r    <= add_ok_nxt;
    out_match_r <= out_match_nxt;
    out_add_r   <= out_add_nxt;
    out_occ_r   <= out_occ_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_match_count  = out_match_r;
  assign out_add_accepted = out_add_r;
  assign out_occupancy    = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("table occupancy exceeds depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ert_pkg::ST_SCAN) |-> (wr_ptr_r <= rd_ptr_r))
    else $error("compaction write pointer passed read pointer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted an item while busy");

  a_add_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_add_r |-> (out_occ_r != '0))
    else $error("accepted add reports empty table");

endmodule
`default_nettype wire

>>> tb/expiring_reservation_table_unit_tb.sv
`default_nettype none
module expiring_reservation_table_unit_tb;
  import ert_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [IN_KEY_W-1:0] KEY_MASK = IN_KEY_W'((1 << KEY_BITS_DEF) - 1);

  typedef struct packed {
    logic [OUT_CNT_W-1:0] match_count;
    logic                 add_accepted;
    logic [OUT_CNT_W-1:0] occupancy;
  } table_result_t;

  typedef struct packed {
    cmd_t                op;
    logic [IN_KEY_W-1:0] key;
    logic [TIME_W-1:0]   now;
    logic [5:0]          reps;
    logic                fixed;
    table_result_t       want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cmd_t                 in_cmd = CMD_NOP;
  logic [IN_KEY_W-1:0]  in_section_key = '0;
  logic [TIME_W-1:0]    in_now_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_CNT_W-1:0] out_match_count;
  logic                 out_add_accepted;
  logic [OUT_CNT_W-1:0] out_occupancy;
  logic                 cfg_wr_en = 1'b0;
  logic [TIME_W-1:0]    cfg_wr_data = '0;

  logic [IN_KEY_W-1:0]  held_key [DEPTH];
  logic [TIME_W-1:0]    held_expiry [DEPTH];
  int                   held_count = 0;
  logic [TIME_W-1:0]    timeout_val = TIMEOUT_RST;

  table_result_t        expected_results [$];
  stim_row_t            directed_rows [$];
  int                   mismatch_count = 0;
  bit                   quiet = 1'b0;

  expiring_reservation_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_section_key   (in_section_key),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_count  (out_match_count),
    .out_add_accepted (out_add_accepted),
    .out_occupancy    (out_occupancy),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic table_result_t apply_table_op(cmd_t op, logic [IN_KEY_W-1:0] key,
                                                   logic [TIME_W-1:0] now);
    table_result_t r;
    int kept;
    r = '0;
    key = key & KEY_MASK;
    case (op)
      CMD_SWEEP: begin
        kept = 0;
        for (int rd = 0; rd < held_count; rd++) begin
          if (!(now > held_expiry[rd])) begin
            held_key[kept] = held_key[rd];
            held_expiry[kept] = held_expiry[rd];
            kept++;
          end
        end
        held_count = kept;
      end
      CMD_ADD: begin
        if (held_count < DEPTH) begin
          held_key[held_count] = key;
          held_expiry[held_count] = now + timeout_val;
          held_count++;
          r.add_accepted = 1'b1;
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < held_count; i++) begin
          if (held_key[i] == key) r.match_count++;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = OUT_CNT_W'(held_count);
    return r;
  endfunction

  function automatic stim_row_t mk_row(cmd_t op, logic [IN_KEY_W-1:0] key,
                                       logic [TIME_W-1:0] now, int reps, bit fixed,
                                       int mc, int acc, int occ);
    stim_row_t s;
    s.op = op;
    s.key = key;
    s.now = now;
    s.reps = 6'(reps);
    s.fixed = fixed;
    s.want.match_count = OUT_CNT_W'(mc);
    s.want.add_accepted = acc[0];
    s.want.occupancy = OUT_CNT_W'(occ);
    return s;
  endfunction

  task automatic issue_op(input cmd_t op, input logic [IN_KEY_W-1:0] key,
                          input logic [TIME_W-1:0] now, input bit fixed,
                          input table_result_t want);
    table_result_t r;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= op;
    in_section_key <= key;
    in_now_time <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_table_op(op, key, now);
    expected_results.push_back(fixed ? want : r);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    timeout_val = value;
  endtask

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    table_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: match_count %0d add_accepted %0d occupancy %0d",
               out_match_count, out_add_accepted, out_occupancy);
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_match_count !== e.match_count) begin
          $error("match_count expected %0d got %0d", e.match_count, out_match_count);
          mismatch_count++;
        end
        if (out_add_accepted !== e.add_accepted) begin
          $error("add_accepted expected %0d got %0d", e.add_accepted, out_add_accepted);
          mismatch_count++;
        end
        if (out_occupancy !== e.occupancy) begin
          $error("occupancy expected %0d got %0d", e.occupancy, out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    logic [TIME_W-1:0] phase_timeout [6];
    int phase_step [6];
    logic [TIME_W-1:0] phase_start [6];
    logic [TIME_W-1:0] cur_time;
    logic [IN_KEY_W-1:0] key;
    logic [TIME_W-1:0] now;
    cmd_t op;
    int pick;
    int item_no;

    for (int i = 0; i < DEPTH; i++) begin
      held_key[i] = '0;
      held_expiry[i] = '0;
    end

    // Timeout is still at its reset value for the whole directed part.
    directed_rows.push_back(mk_row(CMD_COUNT, 8'h00, 32'd0, 1, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_SWEEP, 8'h00, 32'd0, 1, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_NOP, 8'hFF, 32'hFFFF_FFFF, 1, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_ADD, 8'h00, 32'd0, 1, 1, 0, 1, 1));
    directed_rows.push_back(mk_row(CMD_ADD, 8'hFF, 32'd100, 1, 1, 0, 1, 2));
    directed_rows.push_back(mk_row(CMD_COUNT, 8'hFF, 32'd0, 1, 1, 1, 0, 2));
    directed_rows.push_back(mk_row(CMD_SWEEP, 8'h00, 32'd30000, 1, 1, 0, 0, 2));
    directed_rows.push_back(mk_row(CMD_SWEEP, 8'h00, 32'd30001, 1, 1, 0, 0, 1));
    directed_rows.push_back(mk_row(CMD_ADD, 8'hAA, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_SWEEP, 8'h00, 32'd30050, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_ADD, 8'h5A, 32'd1000, 19, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_ADD, 8'h33, 32'd1000, 1, 1, 0, 0, 20));
    directed_rows.push_back(mk_row(CMD_COUNT, 8'h5A, 32'd0, 1, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(CMD_NOP, 8'h00, 32'd0, 1, 1, 0, 0, 20));
    directed_rows.push_back(mk_row(CMD_SWEEP, 8'h00, 32'hFFFF_FFFF, 1, 1, 0, 0, 0));

    phase_timeout[0] = 32'd0;         phase_step[0] = 3;    phase_start[0] = $urandom;
    phase_timeout[1] = 32'hFFFF_FFFF; phase_step[1] = 3;    phase_start[1] = $urandom;
    phase_timeout[2] = 32'd150;       phase_step[2] = 15;   phase_start[2] = 32'hFFFF_FF00;
    phase_timeout[3] = 32'd2000;      phase_step[3] = 100;  phase_start[3] = $urandom;
    phase_timeout[4] = 32'd1;         phase_step[4] = 1;    phase_start[4] = 32'd0;
    phase_timeout[5] = $urandom;      phase_step[5] = $urandom_range(1, 1000);
    phase_start[5] = $urandom;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int n = 0; n < row.reps; n++) begin
        issue_op(row.op, row.key, row.now, row.fixed, row.want);
      end
    end

    // Each phase boundary also drains the block completely before moving on.
    item_no = 0;
    for (int p = 0; p < 6; p++) begin
      write_timeout(phase_timeout[p]);
      cur_time = phase_start[p];
      for (int n = 0; n < 200; n++) begin
        quiet = (item_no >= 500) && (item_no < 750);
        cur_time = cur_time + TIME_W'($urandom_range(0, phase_step[p]));
        now = cur_time;
        case ($urandom_range(0, 3))
          0: key = 8'h00;
          1: key = 8'hFF;
          2: key = 8'h5A;
          default: key = (pick % 2 == 0) ? 8'hA5 : IN_KEY_W'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 45) op = CMD_ADD;
        else if (pick < 70) op = CMD_SWEEP;
        else if (pick < 92) op = CMD_COUNT;
        else if (pick < 96) op = CMD_NOP;
        else begin
          op = cmd_t'($urandom_range(0, 3));
          key = IN_KEY_W'($urandom);
          now = $urandom;
        end
        issue_op(op, key, now, 1'b0, '0);
        item_no++;
      end
    end
    quiet = 1'b0;

    settle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
